/* sv/tgc_pkg.sv */
// Shared types and constants for the touch gesture classifier.
// Holds the configuration record, the poll item, the result record and code enums.
// No dependencies.
`default_nettype none
package tgc_pkg;

	localparam int CoordW    = 12;              // coordinate width (8..15)
	localparam int SizeW     = CoordW + 1;      // panel and screen size registers
	localparam int TimeW     = 32;
	localparam int HoldW     = 16;
	localparam int CountW    = 4;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 16;
	localparam int GestW     = 3;

	localparam logic [CoordW-1:0] CoordMax = {CoordW{1'b1}};
	localparam logic [SizeW-1:0]  SizeReset = SizeW'(1 << CoordW);
	localparam logic [HoldW-1:0]  LongPressReset = HoldW'(600);
	localparam logic [CoordW-1:0] TapSlopReset = CoordW'(24);
	localparam logic [CoordW-1:0] SwipeMinReset = CoordW'(60);

	typedef enum logic [GestW-1:0] {
		GEST_NONE  = 3'd0,
		GEST_TAP   = 3'd1,
		GEST_LONG  = 3'd2,
		GEST_LEFT  = 3'd3,
		GEST_RIGHT = 3'd4,
		GEST_UP    = 3'd5,
		GEST_DOWN  = 3'd6
	} gesture_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ORIENT     = 3'd0,
		CFG_NATIVE_W   = 3'd1,
		CFG_NATIVE_H   = 3'd2,
		CFG_SCREEN_W   = 3'd3,
		CFG_SCREEN_H   = 3'd4,
		CFG_LONG_PRESS = 3'd5,
		CFG_TAP_SLOP   = 3'd6,
		CFG_SWIPE_MIN  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]        orientation;
		logic [SizeW-1:0]  native_width;
		logic [SizeW-1:0]  native_height;
		logic [SizeW-1:0]  screen_width;
		logic [SizeW-1:0]  screen_height;
		logic [HoldW-1:0]  hold_thresh;
		logic [CoordW-1:0] slop_limit;
		logic [CoordW-1:0] swipe_travel;
	} cfg_t;

	typedef struct packed {
		logic              contact;
		logic              read_ok;
		logic [CountW-1:0] point_count;
		logic [CoordW-1:0] raw_x;
		logic [CoordW-1:0] raw_y;
		logic [TimeW-1:0]  now_ms;
	} poll_t;

	typedef struct packed {
		gesture_t          gesture;
		logic [CoordW-1:0] event_x;
		logic [CoordW-1:0] event_y;
		logic [TimeW-1:0]  activity_ms;
	} result_t;

endpackage
`default_nettype wire

/* sv/tgc_map.sv */
// Maps one raw point to screen space: optional inversion, swap, then clamp.
// Pure combinational; depends on tgc_pkg.
`default_nettype none
module tgc_map (
	input  var tgc_pkg::cfg_t                  cfg,
	input  var logic [tgc_pkg::CoordW-1:0]     raw_x,
	input  var logic [tgc_pkg::CoordW-1:0]     raw_y,
	output logic     [tgc_pkg::CoordW-1:0]     map_x,
	output logic     [tgc_pkg::CoordW-1:0]     map_y
);
	import tgc_pkg::*;

	localparam int SW = CoordW + 3;

	logic signed [SW-1:0] inv_x, inv_y, sel_x, sel_y;

	// clamp a signed value to [0, min(size-1, CoordMax)], size 0 acts as 1
	function automatic logic [CoordW-1:0] clamp_coord(input logic signed [SW-1:0] v,
		input logic [SizeW-1:0] size);
		logic [SizeW-1:0]  hi_full;
		logic [CoordW-1:0] hi;
		logic [CoordW-1:0] res;
		hi_full = (size == '0) ? '0 : size - SizeW'(1);
		hi = (hi_full > SizeW'(CoordMax)) ? CoordMax : hi_full[CoordW-1:0];
		if (v < 0)
			res = '0;
		else if (v > $signed({3'b000, hi}))
			res = hi;
		else
			res = v[CoordW-1:0];
		return res;
	endfunction

	always_comb begin
		inv_x = $signed({3'b000, raw_x});
		inv_y = $signed({3'b000, raw_y});
		if (cfg.orientation[0])
			inv_x = $signed({2'b00, cfg.native_width}) - SW'(1) - $signed({3'b000, raw_x});
		if (cfg.orientation[1])
			inv_y = $signed({2'b00, cfg.native_height}) - SW'(1) - $signed({3'b000, raw_y});
		if (cfg.orientation[2]) begin
			sel_x = inv_y;
			sel_y = inv_x;
		end else begin
			sel_x = inv_x;
			sel_y = inv_y;
		end
		map_x = clamp_coord(sel_x, cfg.screen_width);
		map_y = clamp_coord(sel_y, cfg.screen_height);
	end

endmodule
`default_nettype wire

/* sv/tgc_track.sv */
// Contact tracker: press/latest position state, hold timing and gesture decision.
// Updates state on each processed poll; depends on tgc_pkg.
`default_nettype none
module tgc_track (
	input  var logic                           clk,
	input  var logic                           arst_n,
	input  var logic                           adv,
	input  var tgc_pkg::cfg_t                  cfg,
	input  var tgc_pkg::poll_t                 poll,
	input  var logic [tgc_pkg::CoordW-1:0]     map_x,
	input  var logic [tgc_pkg::CoordW-1:0]     map_y,
	output tgc_pkg::result_t                   res
);
	import tgc_pkg::*;

	logic              pressed_q;
	logic [CoordW-1:0] press_x_q, press_y_q, latest_x_q, latest_y_q;
	logic [TimeW-1:0]  press_time_q, activity_q;

	logic              pt_valid, release_ev;
	logic signed [CoordW:0] dx, dy, ndx, ndy;
	logic [CoordW-1:0] adx, ady;
	logic [TimeW-1:0]  held;
	gesture_t          kind;

	assign pt_valid   = poll.contact && poll.read_ok &&
		(poll.point_count == CountW'(1) || poll.point_count == CountW'(2));
	assign release_ev = !poll.contact && pressed_q;

	always_comb begin
		dx   = $signed({1'b0, latest_x_q}) - $signed({1'b0, press_x_q});
		dy   = $signed({1'b0, latest_y_q}) - $signed({1'b0, press_y_q});
		ndx  = -dx;
		ndy  = -dy;
		adx  = dx[CoordW] ? ndx[CoordW-1:0] : dx[CoordW-1:0];
		ady  = dy[CoordW] ? ndy[CoordW-1:0] : dy[CoordW-1:0];
		held = poll.now_ms - press_time_q;

		if (adx < cfg.slop_limit && ady < cfg.slop_limit)
			kind = (held >= TimeW'(cfg.hold_thresh)) ? GEST_LONG : GEST_TAP;
		else if (adx > ady && adx >= cfg.swipe_travel)
			kind = dx[CoordW] ? GEST_LEFT : GEST_RIGHT;
		else if (ady >= cfg.swipe_travel)
			kind = dy[CoordW] ? GEST_UP : GEST_DOWN;
		else
			kind = GEST_TAP;

		res.gesture     = release_ev ? kind : GEST_NONE;
		res.event_x     = release_ev ? press_x_q : '0;
		res.event_y     = release_ev ? press_y_q : '0;
		res.activity_ms = (pt_valid || release_ev) ? poll.now_ms : activity_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q    <= 1'b0;
			press_x_q    <= '0;
			press_y_q    <= '0;
			latest_x_q   <= '0;
			latest_y_q   <= '0;
			press_time_q <= '0;
			activity_q   <= '0;
		end else if (adv) begin
			if (pt_valid) begin
				latest_x_q <= map_x;
				latest_y_q <= map_y;
				activity_q <= poll.now_ms;
				if (!pressed_q) begin
					pressed_q    <= 1'b1;
					press_x_q    <= map_x;
					press_y_q    <= map_y;
					press_time_q <= poll.now_ms;
				end
			end else if (release_ev) begin
				pressed_q  <= 1'b0;
				activity_q <= poll.now_ms;
			end
		end
	end

`ifndef SYNTHESIS
	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !poll.contact |=> !pressed_q)
		else $error("pressed still set after release");
	a_point_presses: assert property (@(posedge clk) disable iff (!arst_n)
		adv && pt_valid |=> pressed_q && latest_x_q == $past(map_x))
		else $error("valid point did not register a press");
	a_gesture_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		res.gesture != GEST_NONE |-> pressed_q && !poll.contact)
		else $error("gesture without a pressed contact");
`endif

endmodule
`default_nettype wire

/* sv/touch_gesture_classifier_top.sv */
// Top level of the touch gesture classifier: config registers, poll register,
// mapper, tracker and result register. Depends on tgc_pkg, tgc_map, tgc_track.
`default_nettype none
// Usage:
//   Polls enter on in_valid/in_ready; each transaction carries contact, read_ok,
//   point_count, raw_x, raw_y and now_ms. Every poll yields exactly one result
//   transaction on out_valid/out_ready: gesture, event_x, event_y, activity_ms.
//   Configuration is written through cfg_we/cfg_index/cfg_data, one register per
//   cycle, while no poll is in flight.
//   Dataflow: a poll accepted on in_valid/in_ready is held in the poll register,
//   mapped and classified from there, and its result is loaded into the result register.
//   Throughput: one poll per cycle while results are taken; the whole decision is a short compare path
//   between the poll register and the result register.
//   Stall: when out_ready is low the result register holds; the poll register
//   still takes one more transaction, after which in_ready drops until the
//   result is taken. Nothing is lost or repeated.
//   Reset: arst_n clears the contact state, empties both registers and loads the
//   configuration defaults (no rotation, 4096 x 4096 panel and screen,
//   600 ms long press, 24 px tap slop, 60 px swipe minimum).
module touch_gesture_classifier_top (
	input  var logic                              clk,
	input  var logic                              arst_n,
	input  var logic                              cfg_we,
	input  var logic [tgc_pkg::CfgIdxW-1:0]       cfg_index,
	input  var logic [tgc_pkg::CfgDataW-1:0]      cfg_data,
	input  var logic                              in_valid,
	output logic                                  in_ready,
	input  var logic                              contact,
	input  var logic                              read_ok,
	input  var logic [tgc_pkg::CountW-1:0]        point_count,
	input  var logic [tgc_pkg::CoordW-1:0]        raw_x,
	input  var logic [tgc_pkg::CoordW-1:0]        raw_y,
	input  var logic [tgc_pkg::TimeW-1:0]         now_ms,
	output logic                                  out_valid,
	input  var logic                              out_ready,
	output logic [tgc_pkg::GestW-1:0]             gesture,
	output logic [tgc_pkg::CoordW-1:0]            event_x,
	output logic [tgc_pkg::CoordW-1:0]            event_y,
	output logic [tgc_pkg::TimeW-1:0]             activity_ms
);
	import tgc_pkg::*;

	cfg_t              cfg_q;
	poll_t             poll_s1;
	logic              valid_s1;
	result_t           res_s2;
	logic              valid_s2;
	result_t           res;
	logic              adv;
	logic [CoordW-1:0] map_x, map_y;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orientation   <= '0;
			cfg_q.native_width  <= SizeReset;
			cfg_q.native_height <= SizeReset;
			cfg_q.screen_width  <= SizeReset;
			cfg_q.screen_height <= SizeReset;
			cfg_q.hold_thresh   <= LongPressReset;
			cfg_q.slop_limit    <= TapSlopReset;
			cfg_q.swipe_travel  <= SwipeMinReset;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ORIENT:     cfg_q.orientation   <= cfg_data[2:0];
				CFG_NATIVE_W:   cfg_q.native_width  <= cfg_data[SizeW-1:0];
				CFG_NATIVE_H:   cfg_q.native_height <= cfg_data[SizeW-1:0];
				CFG_SCREEN_W:   cfg_q.screen_width  <= cfg_data[SizeW-1:0];
				CFG_SCREEN_H:   cfg_q.screen_height <= cfg_data[SizeW-1:0];
				CFG_LONG_PRESS: cfg_q.hold_thresh   <= cfg_data[HoldW-1:0];
				CFG_TAP_SLOP:   cfg_q.slop_limit    <= cfg_data[CoordW-1:0];
				CFG_SWIPE_MIN:  cfg_q.swipe_travel  <= cfg_data[CoordW-1:0];
				default: ;
			endcase
		end
	end

	// poll register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			poll_s1.contact     <= contact;
			poll_s1.read_ok     <= read_ok;
			poll_s1.point_count <= point_count;
			poll_s1.raw_x       <= raw_x;
			poll_s1.raw_y       <= raw_y;
			poll_s1.now_ms      <= now_ms;
		end
	end

	tgc_map u_map (
		.cfg   (cfg_q),
		.raw_x (poll_s1.raw_x),
		.raw_y (poll_s1.raw_y),
		.map_x (map_x),
		.map_y (map_y)
	);

	tgc_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg_q),
		.poll   (poll_s1),
		.map_x  (map_x),
		.map_y  (map_y),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res;
	end

	assign out_valid   = valid_s2;
	assign gesture     = res_s2.gesture;
	assign event_x     = res_s2.event_x;
	assign event_y     = res_s2.event_y;
	assign activity_ms = res_s2.activity_ms;

endmodule
`default_nettype wire
